// ===== design/bleadp_pkg.sv =====
// ----------------------------------------------------------------------------
// bleadp_pkg
// Types and constants shared by the advertising data parser modules.
// ----------------------------------------------------------------------------
package bleadp_pkg;

   localparam int unsigned UUID_W = 16;

   // AD types with special handling
   localparam logic [7:0] AD_UUID16_PARTIAL  = 8'h02;
   localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;
   localparam logic [7:0] AD_NAME_SHORT      = 8'h08;
   localparam logic [7:0] AD_NAME_COMPLETE   = 8'h09;
   localparam logic [7:0] AD_SERVICE_DATA    = 8'h16;

   typedef enum logic [1:0] {
      ROLE_LEN  = 2'd0,
      ROLE_TYPE = 2'd1,
      ROLE_DATA = 2'd2,
      ROLE_IGN  = 2'd3
   } role_type;

   typedef struct packed {
      role_type    byte_role;
      logic [7:0]  field_type;
      logic [7:0]  data_value;
      logic [7:0]  data_index;
      logic        field_complete;
      logic        uuid_match;
      logic        is_name;
      logic        stopped;
      logic        truncated;
   } result_type;

endpackage

// ===== design/bleadp_if.sv =====
// ----------------------------------------------------------------------------
// bleadp_if
// Valid/ready channels for payload bytes in and parse results out.
// ----------------------------------------------------------------------------
interface bleadp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface bleadp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_role;
   logic [7:0] field_type;
   logic [7:0] data_value;
   logic [7:0] data_index;
   logic       field_complete;
   logic       uuid_match;
   logic       is_name;
   logic       stopped;
   logic       truncated;

   modport source (output valid, output byte_role, output field_type, output data_value,
                   output data_index, output field_complete, output uuid_match,
                   output is_name, output stopped, output truncated, input ready);
   modport sink   (input valid, input byte_role, input field_type, input data_value,
                   input data_index, input field_complete, input uuid_match,
                   input is_name, input stopped, input truncated, output ready);
endinterface

// ===== design/bleadp_parser.sv =====
// ----------------------------------------------------------------------------
// bleadp_parser
// Per-payload parse state and the one-byte update that produces a result.
// ----------------------------------------------------------------------------
module bleadp_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [7:0]                     payload_byte,
   input  logic                           last_byte,
   input  logic [bleadp_pkg::UUID_W-1:0]  target_uuid,
   output bleadp_pkg::result_type         result
);

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] pair_ff, pair_in;
   logic       match_ff, match_in;
   logic       taken_ff, taken_in;
   logic       name_ff, name_in;
   logic       stop_ff, stop_in;

   logic [7:0] left_dec;
   logic       uuid_eq;
   logic       is_list;
   logic       is_name_type;

   assign left_dec     = left_ff - 8'd1;
   assign uuid_eq      = ({payload_byte, pair_ff} == target_uuid);
   assign is_list      = (held_ff == bleadp_pkg::AD_UUID16_PARTIAL) ||
                         (held_ff == bleadp_pkg::AD_UUID16_COMPLETE);
   assign is_name_type = (payload_byte == bleadp_pkg::AD_NAME_SHORT) ||
                         (payload_byte == bleadp_pkg::AD_NAME_COMPLETE);

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      pair_in  = pair_ff;
      match_in = match_ff;
      taken_in = taken_ff;
      name_in  = name_ff;
      stop_in  = stop_ff;

      result                = '0;
      result.byte_role      = bleadp_pkg::ROLE_IGN;
      result.data_value     = payload_byte;

      if (stop_ff) begin
         result.byte_role = bleadp_pkg::ROLE_IGN;
      end else begin
         unique case (phase_ff)
            PH_TYPE: begin
               result.byte_role  = bleadp_pkg::ROLE_TYPE;
               result.field_type = payload_byte;
               held_in = payload_byte;
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  // empty field: done at the type byte, never a match
                  result.field_complete = 1'b1;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_DATA;
                  pos_in   = 8'd0;
                  pair_in  = 8'd0;
                  match_in = 1'b0;
                  name_in  = is_name_type && !taken_ff;
                  if (is_name_type && !taken_ff) begin
                     taken_in = 1'b1;
                  end
                  result.truncated = last_byte;
               end
            end
            PH_DATA: begin
               result.byte_role  = bleadp_pkg::ROLE_DATA;
               result.field_type = held_ff;
               result.data_index = pos_ff;
               result.is_name    = name_ff;
               if (!pos_ff[0]) begin
                  pair_in = payload_byte;
               end else begin
                  if ((held_ff == bleadp_pkg::AD_SERVICE_DATA) &&
                      (pos_ff == 8'd1) && uuid_eq) begin
                     match_in = 1'b1;
                  end
                  if (is_list && uuid_eq) begin
                     match_in = 1'b1;
                  end
               end
               pos_in  = pos_ff + 8'd1;
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  result.field_complete = 1'b1;
                  result.uuid_match     = match_in;
                  phase_in = PH_LEN;
                  name_in  = 1'b0;
               end else begin
                  result.truncated = last_byte;
               end
            end
            default: begin
               // length byte; unused phase code lands here too
               result.byte_role = bleadp_pkg::ROLE_LEN;
               if (payload_byte == 8'd0) begin
                  stop_in = 1'b1;
               end else begin
                  left_in  = payload_byte;
                  phase_in = PH_TYPE;
                  result.truncated = last_byte;
               end
            end
         endcase
      end

      result.stopped = stop_in;

      // drop all parse state at the end of a payload
      if (last_byte) begin
         phase_in = PH_LEN;
         left_in  = 8'd0;
         held_in  = 8'd0;
         pos_in   = 8'd0;
         pair_in  = 8'd0;
         match_in = 1'b0;
         taken_in = 1'b0;
         name_in  = 1'b0;
         stop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         left_ff  <= 8'd0;
         held_ff  <= 8'd0;
         pos_ff   <= 8'd0;
         pair_ff  <= 8'd0;
         match_ff <= 1'b0;
         taken_ff <= 1'b0;
         name_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         pair_ff  <= pair_in;
         match_ff <= match_in;
         taken_ff <= taken_in;
         name_ff  <= name_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

// ===== design/ble_ad_structure_parser_core.sv =====
// ----------------------------------------------------------------------------
// ble_ad_structure_parser_core
// Splits a BLE advertising payload into length-type-data structures.
// ----------------------------------------------------------------------------
// Feed one payload byte per beat with last_byte set on the final byte; each
// byte yields exactly one result beat that gives its role, field type, data
// index, completion, UUID match, name marking, stop and truncation flags.
// The block sustains one byte per clock while rsp ready stays high: a byte is
// held in an input register while the parse state updates, and its result is
// loaded into the output register when the step is taken, which waits while a
// held result beat has not been accepted. Write csr_wr_data with csr_wr_en
// only while no bytes are in flight.
module ble_ad_structure_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   bleadp_req_if.sink                     req_bus,
   bleadp_rsp_if.source                   rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [bleadp_pkg::UUID_W-1:0]  csr_wr_data
);

   logic                           in_valid_ff, in_valid_in;
   logic [7:0]                     in_byte_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff, out_valid_in;
   bleadp_pkg::result_type         out_ff;
   bleadp_pkg::result_type         step_result;
   logic [bleadp_pkg::UUID_W-1:0]  uuid_ff;

   logic advance;
   logic step_en;
   logic req_take;

   assign advance  = !out_valid_ff || rsp_bus.ready;
   assign step_en  = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_en ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   bleadp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .payload_byte (in_byte_ff),
      .last_byte    (in_last_ff),
      .target_uuid  (uuid_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         uuid_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            uuid_ff <= csr_wr_data;
         end
      end
   end

   // payload registers: load on accept / advance only
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.payload_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.byte_role      = out_ff.byte_role;
   assign rsp_bus.field_type     = out_ff.field_type;
   assign rsp_bus.data_value     = out_ff.data_value;
   assign rsp_bus.data_index     = out_ff.data_index;
   assign rsp_bus.field_complete = out_ff.field_complete;
   assign rsp_bus.uuid_match     = out_ff.uuid_match;
   assign rsp_bus.is_name        = out_ff.is_name;
   assign rsp_bus.stopped        = out_ff.stopped;
   assign rsp_bus.truncated      = out_ff.truncated;

endmodule

// ===== tb/sv/ble_ad_structure_parser_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ble_ad_structure_parser_core_tb
// Streams advertising payloads through the parser and checks every result
// beat against a cycle-free predictor of the length-type-data parse, under
// random stalls on both channels and several target UUID settings.
// ----------------------------------------------------------------------------
module ble_ad_structure_parser_core_tb;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [1:0] {
      GET_LEN  = 2'd0,
      GET_TYPE = 2'd1,
      GET_DATA = 2'd2
   } parse_state_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [bleadp_pkg::UUID_W-1:0] csr_wr_data;

   bleadp_req_if req_if ();
   bleadp_rsp_if rsp_if ();

   ble_ad_structure_parser_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [bleadp_pkg::UUID_W-1:0] uuid_target;
   parse_state_type   phase;
   logic [7:0]        left_count;
   logic [7:0]        cur_type;
   logic [7:0]        data_pos;
   logic [7:0]        low_byte;
   logic              uuid_hit;
   logic              name_used;
   logic              name_active;
   logic              halted;

   bleadp_pkg::result_type  pending_results[$];
   logic [7:0]  pay_bytes[$];
   int          err_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   logic        gaps_on = 1'b1;

   always #5 clock = ~clock;

   function automatic void clear_parse();
      phase       = GET_LEN;
      left_count  = 8'd0;
      cur_type    = 8'd0;
      data_pos    = 8'd0;
      low_byte    = 8'd0;
      uuid_hit    = 1'b0;
      name_used   = 1'b0;
      name_active = 1'b0;
      halted      = 1'b0;
   endfunction

   function automatic bleadp_pkg::result_type parse_byte(input logic [7:0] b,
                                                         input logic lst);
      bleadp_pkg::result_type r;
      r = '0;
      r.byte_role  = bleadp_pkg::ROLE_IGN;
      r.data_value = b;
      if (halted) begin
         r.byte_role = bleadp_pkg::ROLE_IGN;
      end else if (phase == GET_TYPE) begin
         r.byte_role  = bleadp_pkg::ROLE_TYPE;
         r.field_type = b;
         cur_type     = b;
         left_count   = left_count - 8'd1;
         if (left_count == 8'd0) begin
            // empty field completes on its type byte
            r.field_complete = 1'b1;
            phase = GET_LEN;
         end else begin
            phase       = GET_DATA;
            data_pos    = 8'd0;
            low_byte    = 8'd0;
            uuid_hit    = 1'b0;
            name_active = (b == bleadp_pkg::AD_NAME_SHORT ||
                           b == bleadp_pkg::AD_NAME_COMPLETE) && !name_used;
            if (name_active) name_used = 1'b1;
            r.truncated = lst;
         end
      end else if (phase == GET_DATA) begin
         r.byte_role  = bleadp_pkg::ROLE_DATA;
         r.field_type = cur_type;
         r.data_index = data_pos;
         r.is_name    = name_active;
         if (!data_pos[0]) begin
            low_byte = b;
         end else if ({b, low_byte} == uuid_target) begin
            if ((cur_type == bleadp_pkg::AD_SERVICE_DATA && data_pos == 8'd1) ||
                cur_type == bleadp_pkg::AD_UUID16_PARTIAL ||
                cur_type == bleadp_pkg::AD_UUID16_COMPLETE)
               uuid_hit = 1'b1;
         end
         data_pos   = data_pos + 8'd1;
         left_count = left_count - 8'd1;
         if (left_count == 8'd0) begin
            r.field_complete = 1'b1;
            r.uuid_match     = uuid_hit;
            phase            = GET_LEN;
            name_active      = 1'b0;
         end else begin
            r.truncated = lst;
         end
      end else begin
         r.byte_role = bleadp_pkg::ROLE_LEN;
         if (b == 8'd0) begin
            halted = 1'b1;
         end else begin
            left_count  = b;
            phase       = GET_TYPE;
            r.truncated = lst;
         end
      end
      r.stopped = halted;
      if (lst) clear_parse();
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         err_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
      end
   endtask

   // predict on each accepted byte, then compare each accepted result beat
   always @(posedge clock) begin
      bleadp_pkg::result_type want;
      bleadp_pkg::result_type pred;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            pred = parse_byte(req_if.payload_byte, req_if.last_byte);
            pending_results.insert(pending_results.size(), pred);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               err_count++;
               $display("%0t: result beat with none expected, actual byte 0x%0h",
                        $time, rsp_if.data_value);
            end else begin
               want = pending_results.pop_front();
               check_field("byte_role", want.byte_role, rsp_if.byte_role);
               check_field("field_type", want.field_type, rsp_if.field_type);
               check_field("data_value", want.data_value, rsp_if.data_value);
               check_field("data_index", want.data_index, rsp_if.data_index);
               check_field("field_complete", want.field_complete, rsp_if.field_complete);
               check_field("uuid_match", want.uuid_match, rsp_if.uuid_match);
               check_field("is_name", want.is_name, rsp_if.is_name);
               check_field("stopped", want.stopped, rsp_if.stopped);
               check_field("truncated", want.truncated, rsp_if.truncated);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= (gaps_on && $urandom_range(0, 99) < 14) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic append_byte(input logic [7:0] v);
      pay_bytes.insert(pay_bytes.size(), v);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic lst);
      while (gaps_on && $urandom_range(0, 99) < 14) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.payload_byte <= b;
      req_if.last_byte    <= lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_payload();
      for (int i = 0; i < pay_bytes.size(); i++)
         send_byte(pay_bytes[i], i == pay_bytes.size() - 1);
      pay_bytes.delete();
   endtask

   // drop valid and hold until every predicted beat has come back
   task automatic wait_results_done();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_uuid(input logic [bleadp_pkg::UUID_W-1:0] v);
      wait_results_done();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      uuid_target = v;
   endtask

   task automatic build_random_payload();
      int kind;
      int len;
      int cut;
      logic [7:0] ftype;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
         return;
      end
      repeat ($urandom_range(1, 4)) begin
         len = ($urandom_range(0, 59) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         case ($urandom_range(0, 6))
            0: ftype = bleadp_pkg::AD_UUID16_PARTIAL;
            1: ftype = bleadp_pkg::AD_UUID16_COMPLETE;
            2: ftype = bleadp_pkg::AD_NAME_SHORT;
            3: ftype = bleadp_pkg::AD_NAME_COMPLETE;
            4, 5: ftype = bleadp_pkg::AD_SERVICE_DATA;
            default: ftype = 8'($urandom);
         endcase
         append_byte(8'(len));
         append_byte(ftype);
         for (int j = 0; j < len - 1; j++) begin
            // plant the target UUID on an aligned pair now and then
            if (!j[0] && j + 1 < len - 1 && $urandom_range(0, 2) == 0) begin
               append_byte(uuid_target[7:0]);
               append_byte(uuid_target[15:8]);
               j++;
            end else begin
               append_byte(8'($urandom));
            end
         end
      end
      case (kind)
         7: begin
            append_byte(8'd0);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
         end
         8: begin
            cut = $urandom_range(1, pay_bytes.size() - 1);
            repeat (cut) void'(pay_bytes.pop_back());
         end
         9: append_byte(8'($urandom));
         default: ;
      endcase
   endtask

   task automatic run_stream(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         build_random_payload();
         send_payload();
         if ($urandom_range(0, 19) == 0) wait_results_done();
      end
   endtask

   task automatic test_directed();
      // reset UUID of zero matches a zero service pair; then truncated length
      pay_bytes = '{8'h03, bleadp_pkg::AD_SERVICE_DATA, 8'h00, 8'h00, 8'hFF};
      send_payload();
      write_uuid(16'h180F);
      // service match, empty field, terminator, ignored byte
      pay_bytes = '{8'h03, bleadp_pkg::AD_SERVICE_DATA, 8'h0F, 8'h18,
                    8'h01, 8'hFF, 8'h00, 8'hFF};
      send_payload();
      // list with odd tail holding half the UUID, first and second name fields
      pay_bytes = '{8'h04, bleadp_pkg::AD_UUID16_COMPLETE, 8'h0D, 8'h18, 8'h0F,
                    8'h02, bleadp_pkg::AD_NAME_COMPLETE, 8'h41,
                    8'h02, bleadp_pkg::AD_NAME_SHORT, 8'h43};
      send_payload();
      // payload ends inside a matching list field
      pay_bytes = '{8'h05, bleadp_pkg::AD_UUID16_PARTIAL, 8'h0F, 8'h18};
      send_payload();
      // payload ends on a type byte
      pay_bytes = '{8'h02, 8'hFF};
      send_payload();
   endtask

   task automatic test_random_traffic();
      write_uuid(16'($urandom));
      run_stream(100);
      wait_results_done();
      write_uuid(16'($urandom));
      run_stream(60);
   endtask

   task automatic test_uuid_extremes();
      write_uuid(16'h0000);
      run_stream(50);
      write_uuid(16'hFFFF);
      run_stream(50);
   endtask

   task automatic test_back_to_back();
      wait_results_done();
      gaps_on = 1'b0;
      write_uuid(16'($urandom));
      run_stream(80);
      wait_results_done();
      gaps_on = 1'b1;
   endtask

   task automatic test_long_fields();
      write_uuid(16'($urandom));
      // longest list, target on the last aligned pair
      append_byte(8'hFF);
      append_byte(bleadp_pkg::AD_UUID16_COMPLETE);
      repeat (252) append_byte(8'($urandom));
      append_byte(uuid_target[7:0]);
      append_byte(uuid_target[15:8]);
      send_payload();
      // longest service data, cut short
      append_byte(8'hFF);
      append_byte(bleadp_pkg::AD_SERVICE_DATA);
      append_byte(uuid_target[7:0]);
      append_byte(uuid_target[15:8]);
      repeat (40) append_byte(8'($urandom));
      send_payload();
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_if.valid        = 1'b0;
      req_if.payload_byte = 8'd0;
      req_if.last_byte    = 1'b0;
      rsp_if.ready        = 1'b0;
      uuid_target         = '0;
      clear_parse();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_traffic();
      test_uuid_extremes();
      test_back_to_back();
      test_long_fields();

      wait_results_done();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
